[rtl/imucal_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imucal_pkg
// Shared types and constants for the IMU frame calibration and filter block.
// ----------------------------------------------------------------------------
package imucal_pkg;

  // fixed-point setup
  localparam int FRAC_BITS = 16;
  localparam int PROD_FRAC = 24;
  localparam int OUT_SHIFT = PROD_FRAC - FRAC_BITS;
  localparam int AXES      = 3;
  localparam int MAX_AXES  = 3;

  // filter coefficient of one in Q1.16
  localparam logic [16:0] COEF_ONE = 17'h10000;

  // configuration register indexes
  localparam logic [2:0] REG_GYRO_GAIN    = 3'd0;
  localparam logic [2:0] REG_ACCEL_GAIN   = 3'd1;
  localparam logic [2:0] REG_MAG_GAIN     = 3'd2;
  localparam logic [2:0] REG_GYRO_OFFS    = 3'd3;
  localparam logic [2:0] REG_ACCEL_OFFS   = 3'd4;
  localparam logic [2:0] REG_MAG_OFFS     = 3'd5;
  localparam logic [2:0] REG_ACCEL_SMOOTH = 3'd6;

  // sequencer states, also the step code seen by the lanes
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_G,
    ST_MUL_A,
    ST_MUL_M,
    ST_MUL_F,
    ST_UPD,
    ST_OUT
  } state_t;

  // input word
  typedef struct packed {
    logic signed [15:0] gyro_x_raw;
    logic signed [15:0] gyro_y_raw;
    logic signed [15:0] gyro_z_raw;
    logic signed [15:0] accel_x_raw;
    logic signed [15:0] accel_y_raw;
    logic signed [15:0] accel_z_raw;
    logic signed [15:0] mag_x_raw;
    logic signed [15:0] mag_y_raw;
    logic signed [15:0] mag_z_raw;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
    logic signed [31:0] accel_x_smooth;
    logic signed [31:0] accel_y_smooth;
    logic signed [31:0] accel_z_smooth;
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
    logic               clipped;
  } out_word_t;

  // lane control from the sequencer
  typedef struct packed {
    logic   start;
    state_t step;
  } lane_ctrl_t;

  // per-lane configuration slice
  typedef struct packed {
    logic [31:0] gyro_gain;
    logic [31:0] accel_gain;
    logic [31:0] mag_gain;
    logic [19:0] gyro_off;
    logic [19:0] accel_off;
    logic [19:0] mag_off;
    logic [16:0] coef;
  } lane_cfg_t;

  // per-lane raw samples
  typedef struct packed {
    logic [15:0] gyro;
    logic [15:0] accel;
    logic [15:0] mag;
  } lane_raw_t;

  // per-lane results
  typedef struct packed {
    logic [31:0] rate;
    logic [31:0] accel;
    logic [31:0] field;
    logic        clip;
  } lane_res_t;

endpackage
`default_nettype wire

[rtl/imu_frame_calibrate_filter.sv]
`timescale 1ns / 1ps
`default_nettype none
// After a frame is accepted the sequencer steps through MUL_G, MUL_A, MUL_M, MUL_F,
// UPD and OUT, waits in OUT while the output is stalled, then loads the result word;
// only then is a new frame taken; each lane's single multiplier is shared by four
// products (gyro, accel, mag, filter). Reset (synchronous, active low) clears config,
// sequencer and filter state and out_valid; the block takes frames right after reset.
// ----------------------------------------------------------------------------
// imu_frame_calibrate_filter
// IMU frame calibration with per-axis lanes, offset removal, Q16.16
// saturation and accelerometer low-pass smoothing.
// ----------------------------------------------------------------------------
module imu_frame_calibrate_filter import imucal_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire in_word_t    in_data,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      out_word_t   out_data,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [31:0] gyro_gain_r;
  logic [31:0] accel_gain_r;
  logic [31:0] mag_gain_r;
  logic [59:0] gyro_offs_r;
  logic [59:0] accel_offs_r;
  logic [59:0] mag_offs_r;
  logic [50:0] accel_smooth_r;

  state_t     state_r;
  state_t     state_nxt;
  logic       load;
  logic       start;
  logic       out_busy;
  lane_ctrl_t ctrl;
  lane_raw_t  raw  [MAX_AXES];
  lane_res_t  res  [MAX_AXES];

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_gain_r    <= '0;
      accel_gain_r   <= '0;
      mag_gain_r     <= '0;
      gyro_offs_r    <= '0;
      accel_offs_r   <= '0;
      mag_offs_r     <= '0;
      accel_smooth_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GYRO_GAIN:    gyro_gain_r    <= cfg_data[31:0];
        REG_ACCEL_GAIN:   accel_gain_r   <= cfg_data[31:0];
        REG_MAG_GAIN:     mag_gain_r     <= cfg_data[31:0];
        REG_GYRO_OFFS:    gyro_offs_r    <= cfg_data[59:0];
        REG_ACCEL_OFFS:   accel_offs_r   <= cfg_data[59:0];
        REG_MAG_OFFS:     mag_offs_r     <= cfg_data[59:0];
        REG_ACCEL_SMOOTH: accel_smooth_r <= cfg_data[50:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer next state and strobes
  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_MUL_G;
        end
      end
      ST_MUL_G: state_nxt = ST_MUL_A;
      ST_MUL_A: state_nxt = ST_MUL_M;
      ST_MUL_M: state_nxt = ST_MUL_F;
      ST_MUL_F: state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_busy) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign start      = in_valid & in_ready;
  assign ctrl.start = start;
  assign ctrl.step  = state_r;

  // raw samples per axis
  assign raw[0] = '{gyro: in_data.gyro_x_raw, accel: in_data.accel_x_raw,
                    mag: in_data.mag_x_raw};
  assign raw[1] = '{gyro: in_data.gyro_y_raw, accel: in_data.accel_y_raw,
                    mag: in_data.mag_y_raw};
  assign raw[2] = '{gyro: in_data.gyro_z_raw, accel: in_data.accel_z_raw,
                    mag: in_data.mag_z_raw};

  // axis lanes; unused axes read as zero
  for (genvar g = 0; g < MAX_AXES; g++) begin : g_lane
    if (g < AXES) begin : g_on
      lane_cfg_t lcfg;
      assign lcfg.gyro_gain  = gyro_gain_r;
      assign lcfg.accel_gain = accel_gain_r;
      assign lcfg.mag_gain   = mag_gain_r;
      assign lcfg.gyro_off   = gyro_offs_r[20*g +: 20];
      assign lcfg.accel_off  = accel_offs_r[20*g +: 20];
      assign lcfg.mag_off    = mag_offs_r[20*g +: 20];
      assign lcfg.coef       = accel_smooth_r[17*g +: 17];

      imucal_lane u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .cfg   (lcfg),
        .raw   (raw[g]),
        .res   (res[g])
      );
    end else begin : g_off
      assign res[g] = '0;
    end
  end

  // result merge and output register
  imucal_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .busy      (out_busy)
  );

endmodule
`default_nettype wire

[rtl/imucal_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imucal_lane
// One axis: scales gyro, accel and mag samples through a shared multiplier,
// removes offsets, saturates, and runs the accel low-pass filter.
// ----------------------------------------------------------------------------
module imucal_lane import imucal_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire lane_ctrl_t ctrl,
  input  wire lane_cfg_t  cfg,
  input  wire lane_raw_t  raw,
  output      lane_res_t  res
);

  localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;

  // clamp to signed 32 bits, clip flag on top
  function automatic logic [32:0] sat32(input logic signed [51:0] x);
    logic [32:0] r;
    if (x > SAT_MAX) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (x < SAT_MIN) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

  lane_raw_t          raw_r;
  logic signed [50:0] prod_r;
  logic [31:0]        rate_r;
  logic [31:0]        acc_r;
  logic [31:0]        field_r;
  logic [31:0]        filt_r;
  logic               clip_r;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_full;
  logic [16:0]        coef_c;
  logic [19:0]        off_sel;
  logic signed [50:0] off_ext;
  logic signed [50:0] cal_diff;
  logic signed [50:0] cal_shift;
  logic [32:0]        cal_sat;
  logic signed [50:0] filt_step;
  logic signed [51:0] filt_sum;
  logic [32:0]        filt_sat;

  // coefficient above one acts as one
  assign coef_c = (cfg.coef > COEF_ONE) ? COEF_ONE : cfg.coef;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.step)
      ST_MUL_G: begin
        mul_a = $signed({{17{raw_r.gyro[15]}}, raw_r.gyro});
        mul_b = $signed({1'b0, cfg.gyro_gain});
      end
      ST_MUL_A: begin
        mul_a = $signed({{17{raw_r.accel[15]}}, raw_r.accel});
        mul_b = $signed({1'b0, cfg.accel_gain});
      end
      ST_MUL_M: begin
        mul_a = $signed({{17{raw_r.mag[15]}}, raw_r.mag});
        mul_b = $signed({1'b0, cfg.mag_gain});
      end
      ST_MUL_F: begin
        mul_a = $signed({acc_r[31], acc_r}) - $signed({filt_r[31], filt_r});
        mul_b = $signed({16'b0, coef_c});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  // offset of the product registered in the previous step
  always_comb begin
    case (ctrl.step)
      ST_MUL_A: off_sel = cfg.gyro_off;
      ST_MUL_M: off_sel = cfg.accel_off;
      ST_MUL_F: off_sel = cfg.mag_off;
      default:  off_sel = '0;
    endcase
  end

  // offset removal, floor shift and saturation
  assign off_ext   = $signed({{23{off_sel[19]}}, off_sel, 8'b0});
  assign cal_diff  = prod_r - off_ext;
  assign cal_shift = cal_diff >>> OUT_SHIFT;
  assign cal_sat   = sat32({cal_shift[50], cal_shift});

  // filter update
  assign filt_step = prod_r >>> 16;
  assign filt_sum  = $signed({filt_step[50], filt_step}) +
                     $signed({{20{filt_r[31]}}, filt_r});
  assign filt_sat  = sat32(filt_sum);

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      raw_r <= raw;
    end
    case (ctrl.step)
      ST_MUL_G: prod_r <= prod_full[50:0];
      ST_MUL_A: begin
        rate_r <= cal_sat[31:0];
        prod_r <= prod_full[50:0];
      end
      ST_MUL_M: begin
        acc_r  <= cal_sat[31:0];
        prod_r <= prod_full[50:0];
      end
      ST_MUL_F: begin
        field_r <= cal_sat[31:0];
        prod_r  <= prod_full[50:0];
      end
      default: ;
    endcase
  end

  // filter state and frame clip flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
      clip_r <= 1'b0;
    end else begin
      if (ctrl.start) begin
        clip_r <= 1'b0;
      end else if (ctrl.step == ST_MUL_A || ctrl.step == ST_MUL_M ||
                   ctrl.step == ST_MUL_F) begin
        clip_r <= clip_r | cal_sat[32];
      end else if (ctrl.step == ST_UPD) begin
        clip_r <= clip_r | filt_sat[32];
      end
      if (ctrl.step == ST_UPD) begin
        filt_r <= filt_sat[31:0];
      end
    end
  end

  assign res.rate  = rate_r;
  assign res.accel = filt_r;
  assign res.field = field_r;
  assign res.clip  = clip_r;

endmodule
`default_nettype wire

[rtl/imucal_merge.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imucal_merge
// Gathers the lane results into one result word, merges the clip flags and
// holds the word in the output register until it is taken.
// ----------------------------------------------------------------------------
module imucal_merge import imucal_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire lane_res_t res [MAX_AXES],
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_word_t out_data,
  output      logic      busy
);

  logic      out_valid_r;
  out_word_t out_data_r;
  out_word_t word_nxt;

  // pack the lanes
  always_comb begin
    word_nxt.rate_x         = res[0].rate;
    word_nxt.rate_y         = res[1].rate;
    word_nxt.rate_z         = res[2].rate;
    word_nxt.accel_x_smooth = res[0].accel;
    word_nxt.accel_y_smooth = res[1].accel;
    word_nxt.accel_z_smooth = res[2].accel;
    word_nxt.field_x        = res[0].field;
    word_nxt.field_y        = res[1].field;
    word_nxt.field_z        = res[2].field;
    word_nxt.clipped        = res[0].clip | res[1].clip | res[2].clip;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign busy      = out_valid_r & ~out_ready;

endmodule
`default_nettype wire

[rtl/imucal_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imucal_checker
// Port-level checks on the frame sequencing and the result channel.
// ----------------------------------------------------------------------------
module imucal_checker import imucal_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one frame at a time: no accept in the cycle after an accept
  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("frame accepted while previous frame in work");

  // a result word appears only while the input side is closed
  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result word without a frame in work");

  // reset empties the output and opens the input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset state wrong");

endmodule

bind imu_frame_calibrate_filter imucal_checker u_imucal_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

[tb/imucal_sb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imucal_sb_pkg
// Scoreboard for the IMU frame calibration block. It keeps its own copy of
// the gain, offset and smoothing registers and of the accelerometer filter
// state, predicts the result word of each accepted frame and checks the
// result words in order.
// ----------------------------------------------------------------------------
package imucal_sb_pkg;
  import imucal_pkg::*;

  // sensor slots in the gain and offset arrays
  localparam int SENS_GYRO  = 0;
  localparam int SENS_ACCEL = 1;
  localparam int SENS_MAG   = 2;

  // an index the block does not decode
  localparam logic [2:0] REG_UNUSED = 3'd7;

  localparam int MAX_REPORTS = 10;

  class imu_frame_scoreboard;
    logic [31:0]        gain [3];
    logic [59:0]        offs [3];
    logic [50:0]        smooth;
    logic signed [31:0] lowpass [3];
    out_word_t          calibrated_frames [$];
    int unsigned        mismatches;

    function new();
      for (int s = 0; s < 3; s++) begin
        gain[s]    = '0;
        offs[s]    = '0;
        lowpass[s] = '0;
      end
      smooth     = '0;
      mismatches = 0;
    endfunction

    // mirror of one register write; unknown indexes leave everything alone
    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        REG_GYRO_GAIN:    gain[SENS_GYRO]  = val[31:0];
        REG_ACCEL_GAIN:   gain[SENS_ACCEL] = val[31:0];
        REG_MAG_GAIN:     gain[SENS_MAG]   = val[31:0];
        REG_GYRO_OFFS:    offs[SENS_GYRO]  = val[59:0];
        REG_ACCEL_OFFS:   offs[SENS_ACCEL] = val[59:0];
        REG_MAG_OFFS:     offs[SENS_MAG]   = val[59:0];
        REG_ACCEL_SMOOTH: smooth           = val[50:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint x, inout bit clip);
      if (x > 64'sd2147483647) begin
        clip = 1'b1;
        return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
        clip = 1'b1;
        return -64'sd2147483648;
      end
      return x;
    endfunction

    // gain product with 24 fraction bits, minus the scaled offset, floored
    function longint calibrate(logic signed [15:0] raw, logic [31:0] g,
                               logic [59:0] o60, int axis, inout bit clip);
      logic signed [19:0] o;
      longint p;
      longint d;
      o = o60[20*axis +: 20];
      p = longint'(raw) * longint'(g);
      d = (p - longint'(o) * 256) >>> OUT_SHIFT;
      return clamp32(d, clip);
    endfunction

    // predict the result word of an accepted frame and advance the filter
    function void note_frame(in_word_t w);
      logic signed [15:0] raw [9];
      logic [31:0]        r [9];
      out_word_t          e;
      bit                 clip;
      logic [16:0]        c;
      longint             ac;
      longint             f;
      raw = '{w.gyro_x_raw, w.gyro_y_raw, w.gyro_z_raw,
              w.accel_x_raw, w.accel_y_raw, w.accel_z_raw,
              w.mag_x_raw, w.mag_y_raw, w.mag_z_raw};
      clip = 1'b0;
      for (int i = 0; i < 9; i++) r[i] = '0;
      for (int a = 0; a < AXES; a++) begin
        r[a]     = 32'(calibrate(raw[a], gain[SENS_GYRO], offs[SENS_GYRO], a, clip));
        ac       = calibrate(raw[3+a], gain[SENS_ACCEL], offs[SENS_ACCEL], a, clip);
        r[6+a]   = 32'(calibrate(raw[6+a], gain[SENS_MAG], offs[SENS_MAG], a, clip));
        // coefficients above one act as one
        c = smooth[17*a +: 17];
        if (c > COEF_ONE) c = COEF_ONE;
        f = longint'(lowpass[a]);
        f = clamp32(f + (((ac - f) * longint'(c)) >>> 16), clip);
        lowpass[a] = 32'(f);
        r[3+a]     = lowpass[a];
      end
      e.rate_x         = r[0];
      e.rate_y         = r[1];
      e.rate_z         = r[2];
      e.accel_x_smooth = r[3];
      e.accel_y_smooth = r[4];
      e.accel_z_smooth = r[5];
      e.field_x        = r[6];
      e.field_y        = r[7];
      e.field_z        = r[8];
      e.clipped        = clip;
      calibrated_frames.push_back(e);
    endfunction

    // compare a result word with the oldest prediction, field by field
    function void check_result(out_word_t got);
      out_word_t   want;
      logic [31:0] w [10];
      logic [31:0] g [10];
      string       fname [10];
      if (calibrated_frames.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result word %h", got);
        mismatches++;
        return;
      end
      want  = calibrated_frames.pop_front();
      fname = '{"rate_x", "rate_y", "rate_z", "accel_x_smooth", "accel_y_smooth",
                "accel_z_smooth", "field_x", "field_y", "field_z", "clipped"};
      w = '{want.rate_x, want.rate_y, want.rate_z, want.accel_x_smooth,
            want.accel_y_smooth, want.accel_z_smooth, want.field_x, want.field_y,
            want.field_z, 32'(want.clipped)};
      g = '{got.rate_x, got.rate_y, got.rate_z, got.accel_x_smooth,
            got.accel_y_smooth, got.accel_z_smooth, got.field_x, got.field_y,
            got.field_z, 32'(got.clipped)};
      for (int i = 0; i < 10; i++) begin
        if (g[i] !== w[i]) begin
          if (mismatches < MAX_REPORTS)
            $display("mismatch on %s: expected %h, got %h", fname[i], w[i], g[i]);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return calibrated_frames.size();
    endfunction
  endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives IMU frames into the calibration and filter block under random
// gaps and output stalls, walks the configuration through zero, full-scale
// and random settings, and checks every result word against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top import imucal_pkg::*, imucal_sb_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_FRAMES   = 180;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  imu_frame_scoreboard sb;
  bit calm;

  imu_frame_calibrate_filter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle cycles before a word, none during calm stretches
  function automatic int unsigned gap();
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_word_t random_frame();
    in_word_t w;
    for (int i = 0; i < 9; i++) w[16*i +: 16] = rand_sample();
    return w;
  endfunction

  // frame with samples alternating between two values
  function automatic in_word_t fill_frame(logic [15:0] a, logic [15:0] b);
    in_word_t w;
    for (int i = 0; i < 9; i++) w[16*i +: 16] = (i % 2 == 0) ? a : b;
    return w;
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 5))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h0;
      2:       return $urandom;
      default: return $urandom_range(0, 32'h0040_0000);
    endcase
  endfunction

  function automatic logic [16:0] rand_coef();
    case ($urandom_range(0, 7))
      0:       return 17'h0;
      1:       return COEF_ONE;
      2:       return COEF_ONE + 17'd1;
      3:       return 17'h1FFFF;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // one input word; valid stays up across back-to-back words
  task automatic send_frame(in_word_t w);
    int unsigned n;
    n = gap();
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    in_data  = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_frame(w);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold off input until every predicted word has come back
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_config();
    logic [63:0] v;
    cfg_write(REG_GYRO_GAIN,  {$urandom, rand_gain()});
    cfg_write(REG_ACCEL_GAIN, {$urandom, rand_gain()});
    cfg_write(REG_MAG_GAIN,   {$urandom, rand_gain()});
    cfg_write(REG_GYRO_OFFS,  {$urandom, $urandom});
    cfg_write(REG_ACCEL_OFFS, {$urandom, $urandom});
    cfg_write(REG_MAG_OFFS,   {$urandom, $urandom});
    v = {$urandom, $urandom};
    v[16:0]  = rand_coef();
    v[33:17] = rand_coef();
    v[50:34] = rand_coef();
    cfg_write(REG_ACCEL_SMOOTH, v);
    if ($urandom_range(0, 1) == 0) cfg_write(REG_UNUSED, {$urandom, $urandom});
  endtask

  // result side: random stall before each word
  initial begin
    int unsigned n;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      n = gap();
      if (n > 0) begin
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
    end
  end

  // watchdog on cycles with no word moving on any channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    sb        = new();
    calm      = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_GYRO_GAIN;
    cfg_data  = '0;
    rst_n     = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // registers at reset: everything comes out zero
    send_frame(fill_frame(16'h0000, 16'h0000));
    send_frame(fill_frame(16'h7FFF, 16'h7FFF));
    send_frame(fill_frame(16'h8000, 16'h8000));
    wait_for_results();

    // full-scale gains, extreme offsets, filter coefficients zero, one, above one
    cfg_write(REG_GYRO_GAIN,  64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(REG_ACCEL_GAIN, 64'h0000_0000_FFFF_FFFF);
    cfg_write(REG_MAG_GAIN,   64'hA5A5_A5A5_FFFF_FFFF);
    cfg_write(REG_GYRO_OFFS,  64'hF000_0007_FFFF_0000 | 64'h0000_0000_0008_0000);
    cfg_write(REG_ACCEL_OFFS, {4'hF, 20'h00000, 20'h7FFFF, 20'h80000});
    cfg_write(REG_MAG_OFFS,   {4'hA, 20'h80000, 20'h80000, 20'h7FFFF});
    cfg_write(REG_ACCEL_SMOOTH, {13'h1FFF, 17'h1FFFF, COEF_ONE, 17'h0});
    send_frame(fill_frame(16'h7FFF, 16'h7FFF));
    send_frame(fill_frame(16'h8000, 16'h8000));
    send_frame(fill_frame(16'hFFFF, 16'hFFFF));
    send_frame(fill_frame(16'h0001, 16'h0001));
    send_frame(fill_frame(16'h0000, 16'h0000));
    send_frame(fill_frame(16'h7FFF, 16'h8000));
    wait_for_results();

    // unit gains right at the saturation edge, half-step filter
    cfg_write(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(REG_GYRO_GAIN,  64'h0100_0000);
    cfg_write(REG_ACCEL_GAIN, 64'h0100_0000);
    cfg_write(REG_MAG_GAIN,   64'h0100_0000);
    cfg_write(REG_GYRO_OFFS,  {4'h0, 20'h80000, 20'h80000, 20'h80000});
    cfg_write(REG_ACCEL_OFFS, {4'h0, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF});
    cfg_write(REG_ACCEL_SMOOTH, {13'h0, 17'h08000, 17'h08000, COEF_ONE + 17'd1});
    send_frame(fill_frame(16'h7FFF, 16'h7FFF));
    send_frame(fill_frame(16'h8000, 16'h8000));
    send_frame(fill_frame(16'h8000, 16'h7FFF));
    send_frame(fill_frame(16'h0000, 16'h0000));
    send_frame(fill_frame(16'h0000, 16'h0000));
    wait_for_results();

    // zero gains leave only the offsets
    cfg_write(REG_GYRO_GAIN,  64'h0);
    cfg_write(REG_ACCEL_GAIN, 64'h0);
    cfg_write(REG_MAG_GAIN,   64'h0);
    cfg_write(REG_MAG_OFFS,   {$urandom, $urandom});
    send_frame(random_frame());
    send_frame(random_frame());
    wait_for_results();

    // random settings, one calm phase with no idling on either side
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_config();
      calm = (p == 3);
      for (int i = 0; i < PHASE_FRAMES; i++) begin
        send_frame(random_frame());
        if ($urandom_range(0, 99) == 0) wait_for_results();
      end
      wait_for_results();
    end
    calm = 1'b0;

    // drain and finish
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
